/* src/rfc3339_timestamp_parse_assert.svh */
// assertion macros used by the timestamp parser back module (rtp_back)
`ifndef RFC3339_TIMESTAMP_PARSE_ASSERT_SVH
`define RFC3339_TIMESTAMP_PARSE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define RTP_ASSERT_SAME(name, clk, rst_n, trig, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("rtp check failed");

// condition must hold in the cycle after the trigger
`define RTP_ASSERT_NEXT(name, clk, rst_n, trig, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("rtp check failed");

`endif

/* src/rtp_pkg.sv */
package rtp_pkg;

	// input and result transactions
	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
	} in_t;

	typedef struct packed {
		logic               status;
		logic signed [63:0] timestamp_ns;
	} out_t;

	// parsed fields of one timestamp, handed from front to back
	typedef struct packed {
		logic        err;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [29:0] frac_accum;
		logic [3:0]  frac_count;
		logic        off_neg;
		logic [6:0]  off_hours;
		logic [6:0]  off_minutes;
	} rec_t;

	typedef enum logic [2:0] {
		PH_FIXED,
		PH_AFTER_SEC,
		PH_FRACTION,
		PH_COMPLETE,
		PH_OFFSET
	} phase_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_PREP,
		BS_DAYS,
		BS_SECS,
		BS_MUL_LO,
		BS_MUL_HI,
		BS_DONE
	} bstate_t;

	// characters
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UT    = 8'h54;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	// arithmetic constants
	localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [13:0] RECIP_25    = 14'd5243;
	localparam logic [14:0] RECIP_5     = 15'd6554;
	// epoch shift plus one extra era so the year stays positive
	localparam int DAY_BIAS = 719468 + 146097;

	// scale of a fraction with the given number of digits
	function automatic logic [29:0] frac_scale(input logic [3:0] count);
		logic [29:0] s;
		case (count)
			4'd1: s = 30'd100000000;
			4'd2: s = 30'd10000000;
			4'd3: s = 30'd1000000;
			4'd4: s = 30'd100000;
			4'd5: s = 30'd10000;
			4'd6: s = 30'd1000;
			4'd7: s = 30'd100;
			4'd8: s = 30'd10;
			4'd9: s = 30'd1;
			default: s = 30'd0;
		endcase
		return s;
	endfunction

	function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
		logic [4:0] d;
		case (month)
			7'd2: d = leap ? 5'd29 : 5'd28;
			7'd4, 7'd6, 7'd9, 7'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

/* src/rtp_front.sv */
module rtp_front #(
	parameter int FRACTION_DIGITS = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rtp_pkg::in_t  in_data,
	output logic          push,
	output rtp_pkg::rec_t push_rec,
	input  logic          q_full
);
	import rtp_pkg::*;

	localparam logic [3:0] FD = 4'(FRACTION_DIGITS);

	phase_t      phase_q, nx_phase;
	logic [4:0]  idx_q, nx_idx;
	logic [13:0] year_q, nx_year;
	logic [6:0]  month_q, nx_month, day_q, nx_day, hour_q, nx_hour;
	logic [6:0]  min_q, nx_min, sec_q, nx_sec;
	logic [29:0] facc_q, nx_facc;
	logic [3:0]  fcnt_q, nx_fcnt;
	logic        neg_q, nx_neg;
	logic [6:0]  offh_q, nx_offh, offm_q, nx_offm;
	logic        err_q, nx_err;
	logic        take;
	logic [7:0]  c;
	logic [3:0]  dv;
	logic        dig, zone;

	function automatic logic [6:0] pair_add(input logic [6:0] acc, input logic [3:0] d);
		logic [10:0] t;
		t = {4'd0, acc} * 11'd10 + {7'd0, d};
		return t[6:0];
	endfunction

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign c        = in_data.char_byte;
	assign dv       = c[3:0];
	assign dig      = (c >= CH_ZERO) && (c <= CH_NINE);

	// per-character parse step
	always_comb begin
		logic [17:0] yt;
		logic [33:0] ft;
		nx_phase = phase_q;
		nx_idx   = idx_q;
		nx_year  = year_q;
		nx_month = month_q;
		nx_day   = day_q;
		nx_hour  = hour_q;
		nx_min   = min_q;
		nx_sec   = sec_q;
		nx_facc  = facc_q;
		nx_fcnt  = fcnt_q;
		nx_neg   = neg_q;
		nx_offh  = offh_q;
		nx_offm  = offm_q;
		nx_err   = err_q;
		zone     = 1'b0;
		yt = {4'd0, year_q} * 18'd10 + {14'd0, dv};
		ft = {4'd0, facc_q} * 34'd10 + {30'd0, dv};
		if (!err_q) begin
			case (phase_q)
				PH_FIXED: begin
					if (idx_q == 5'd4 || idx_q == 5'd7) begin
						if (c != CH_DASH) nx_err = 1'b1;
					end else if (idx_q == 5'd10) begin
						if (c != CH_UT && c != CH_LT) nx_err = 1'b1;
					end else if (idx_q == 5'd13 || idx_q == 5'd16) begin
						if (c != CH_COLON) nx_err = 1'b1;
					end else if (!dig) begin
						nx_err = 1'b1;
					end else if (idx_q < 5'd4) begin
						nx_year = yt[13:0];
					end else if (idx_q < 5'd7) begin
						nx_month = pair_add(month_q, dv);
					end else if (idx_q < 5'd10) begin
						nx_day = pair_add(day_q, dv);
					end else if (idx_q < 5'd13) begin
						nx_hour = pair_add(hour_q, dv);
					end else if (idx_q < 5'd16) begin
						nx_min = pair_add(min_q, dv);
					end else begin
						nx_sec = pair_add(sec_q, dv);
					end
					if (idx_q >= 5'd18) nx_phase = PH_AFTER_SEC;
					else nx_idx = idx_q + 5'd1;
				end
				PH_AFTER_SEC: begin
					if (c == CH_DOT) nx_phase = PH_FRACTION;
					else zone = 1'b1;
				end
				PH_FRACTION: begin
					if (dig) begin
						if (fcnt_q < FD) nx_facc = ft[29:0];
						if (fcnt_q < 4'd10) nx_fcnt = fcnt_q + 4'd1;
					end else if (fcnt_q == 4'd0 || fcnt_q > FD) begin
						nx_err = 1'b1;
					end else begin
						zone = 1'b1;
					end
				end
				PH_OFFSET: begin
					if (idx_q == 5'd2) begin
						if (c != CH_COLON) nx_err = 1'b1;
					end else if (!dig) begin
						nx_err = 1'b1;
					end else if (idx_q < 5'd2) begin
						nx_offh = pair_add(offh_q, dv);
					end else begin
						nx_offm = pair_add(offm_q, dv);
					end
					if (idx_q >= 5'd4) nx_phase = PH_COMPLETE;
					else nx_idx = idx_q + 5'd1;
				end
				default: nx_err = 1'b1;
			endcase
			// zone designator
			if (zone) begin
				if (c == CH_UZ || c == CH_LZ) begin
					nx_phase = PH_COMPLETE;
				end else if (c == CH_PLUS || c == CH_DASH) begin
					nx_neg   = (c == CH_DASH);
					nx_phase = PH_OFFSET;
					nx_idx   = 5'd0;
				end else begin
					nx_err = 1'b1;
				end
			end
		end
	end

	// record handed to the back on the final character
	always_comb begin
		push                 = take && in_data.last_char;
		push_rec.err         = nx_err || (nx_phase != PH_COMPLETE);
		push_rec.year        = nx_year;
		push_rec.month       = nx_month;
		push_rec.day         = nx_day;
		push_rec.hour        = nx_hour;
		push_rec.minute      = nx_min;
		push_rec.second      = nx_sec;
		push_rec.frac_accum  = nx_facc;
		push_rec.frac_count  = nx_fcnt;
		push_rec.off_neg     = nx_neg;
		push_rec.off_hours   = nx_offh;
		push_rec.off_minutes = nx_offm;
	end

	// parse state, cleared after each timestamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIXED;
			idx_q   <= '0;
			year_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			facc_q  <= '0;
			fcnt_q  <= '0;
			neg_q   <= 1'b0;
			offh_q  <= '0;
			offm_q  <= '0;
			err_q   <= 1'b0;
		end else if (take) begin
			if (in_data.last_char) begin
				phase_q <= PH_FIXED;
				idx_q   <= '0;
				year_q  <= '0;
				month_q <= '0;
				day_q   <= '0;
				hour_q  <= '0;
				min_q   <= '0;
				sec_q   <= '0;
				facc_q  <= '0;
				fcnt_q  <= '0;
				neg_q   <= 1'b0;
				offh_q  <= '0;
				offm_q  <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= nx_phase;
				idx_q   <= nx_idx;
				year_q  <= nx_year;
				month_q <= nx_month;
				day_q   <= nx_day;
				hour_q  <= nx_hour;
				min_q   <= nx_min;
				sec_q   <= nx_sec;
				facc_q  <= nx_facc;
				fcnt_q  <= nx_fcnt;
				neg_q   <= nx_neg;
				offh_q  <= nx_offh;
				offm_q  <= nx_offm;
				err_q   <= nx_err;
			end
		end
	end

endmodule

/* src/rtp_fifo.sv */
module rtp_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rtp_pkg::rec_t push_rec,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output rtp_pkg::rec_t pop_rec
);
	import rtp_pkg::*;

	rec_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_rec = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_rec;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

/* src/rtp_back.sv */
`include "rfc3339_timestamp_parse_assert.svh"
module rtp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	output logic          pop,
	input  rtp_pkg::rec_t pop_rec,
	output logic          out_valid,
	input  logic          out_ready,
	output rtp_pkg::out_t out_data
);
	import rtp_pkg::*;

	bstate_t            st_q, st_nx;
	rec_t               rec_q;
	logic               bad_q;
	logic [13:0]        yp_q;
	logic [8:0]         doy_q;
	logic signed [18:0] hms_q;
	logic [29:0]        frac_q;
	logic signed [24:0] days_q;
	logic signed [39:0] secs_q;
	logic [49:0]        plo_q;
	logic signed [50:0] phi_q;
	logic               out_valid_q;
	out_t               out_q;
	logic               load;

	// range checks and small products from the parsed fields
	logic        leap, bad;
	logic [13:0] q100;
	logic [25:0] q100_full;
	logic [4:0]  dim;
	logic [6:0]  mm;
	logic [10:0] doy_num;
	logic [25:0] doy_div;
	logic [8:0]  doy;
	logic [13:0] yp;
	logic [16:0] hms_base, off;
	logic signed [18:0] hms;
	logic [59:0] frac_full;

	always_comb begin
		q100_full = {14'd0, rec_q.year[13:2]} * {12'd0, RECIP_25};
		q100      = {5'd0, q100_full[25:17]};
		leap      = (rec_q.year[1:0] == 2'd0)
		            && ((rec_q.year != q100 * 14'd100) || (q100[1:0] == 2'd0));
		dim       = month_len(rec_q.month, leap);
		bad = rec_q.err || (rec_q.month < 7'd1) || (rec_q.month > 7'd12)
		      || (rec_q.day < 7'd1) || (rec_q.day > {2'd0, dim})
		      || (rec_q.hour > 7'd23) || (rec_q.minute > 7'd59) || (rec_q.second > 7'd59)
		      || (rec_q.off_hours > 7'd23) || (rec_q.off_minutes > 7'd59);
		mm        = (rec_q.month > 7'd2) ? rec_q.month - 7'd3 : rec_q.month + 7'd9;
		doy_num   = {4'd0, mm} * 11'd153 + 11'd2;
		doy_div   = {15'd0, doy_num} * {11'd0, RECIP_5};
		doy       = doy_div[23:15] + {2'd0, rec_q.day} - 9'd1;
		yp        = rec_q.year + 14'd400 - ((rec_q.month <= 7'd2) ? 14'd1 : 14'd0);
		hms_base  = {10'd0, rec_q.hour} * 17'd3600 + {10'd0, rec_q.minute} * 17'd60
		            + {10'd0, rec_q.second};
		off       = {10'd0, rec_q.off_hours} * 17'd3600 + {10'd0, rec_q.off_minutes} * 17'd60;
		hms       = rec_q.off_neg ? $signed({2'd0, hms_base}) + $signed({2'd0, off})
		                          : $signed({2'd0, hms_base}) - $signed({2'd0, off});
		frac_full = {30'd0, rec_q.frac_accum} * {30'd0, frac_scale(rec_q.frac_count)};
	end

	// days from the civil date, shifted up by one era
	logic [25:0]        qa, qb;
	logic signed [25:0] dsum;
	always_comb begin
		qa   = {14'd0, yp_q[13:2]} * {12'd0, RECIP_25};
		qb   = {14'd0, 2'd0, yp_q[13:4]} * {12'd0, RECIP_25};
		dsum = $signed({12'd0, yp_q}) * 26'sd365 + $signed({14'd0, yp_q[13:2]})
		       - $signed({14'd0, qa[25:17] & 9'h1FF, 3'd0} >> 3)
		       + $signed({14'd0, qb[25:17] & 9'h1FF, 3'd0} >> 3)
		       + $signed({17'd0, doy_q}) - 26'(DAY_BIAS);
	end

	// seconds, then nanoseconds in two partial products
	logic signed [42:0] sx;
	logic [49:0]        plo;
	logic signed [50:0] phi;
	logic signed [71:0] nsum;
	logic               fits;
	always_comb begin
		sx   = 43'(days_q) * 43'sd86400 + 43'(hms_q);
		plo  = {30'd0, secs_q[19:0]} * {20'd0, NS_PER_SEC};
		phi  = 51'($signed(secs_q[39:20])) * 51'sd1000000000;
		nsum = (72'(phi_q) <<< 20) + $signed({22'd0, plo_q}) + $signed({42'd0, frac_q});
		// signed 64-bit range of the full sum, lower bound on whole seconds
		fits = ((&nsum[71:63]) || !(|nsum[71:63]))
		       && (secs_q >= -40'sd9223372036);
	end

	// sequencer
	always_comb begin
		st_nx = st_q;
		pop   = 1'b0;
		load  = 1'b0;
		case (st_q)
			BS_IDLE: begin
				if (!q_empty) begin
					pop   = 1'b1;
					st_nx = BS_PREP;
				end
			end
			BS_PREP:   st_nx = BS_DAYS;
			BS_DAYS:   st_nx = BS_SECS;
			BS_SECS:   st_nx = BS_MUL_LO;
			BS_MUL_LO: st_nx = BS_MUL_HI;
			BS_MUL_HI: st_nx = BS_DONE;
			BS_DONE: begin
				if (!out_valid_q || out_ready) begin
					load  = 1'b1;
					st_nx = BS_IDLE;
				end
			end
			default: st_nx = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BS_IDLE;
		else st_q <= st_nx;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) rec_q <= pop_rec;
		if (st_q == BS_PREP) begin
			bad_q  <= bad;
			yp_q   <= yp;
			doy_q  <= doy;
			hms_q  <= hms;
			frac_q <= frac_full[29:0];
		end
		if (st_q == BS_DAYS) days_q <= dsum[24:0];
		if (st_q == BS_SECS) secs_q <= sx[39:0];
		if (st_q == BS_MUL_LO) plo_q <= plo;
		if (st_q == BS_MUL_HI) phi_q <= phi;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.status       <= bad_q || !fits;
			out_q.timestamp_ns <= (bad_q || !fits) ? 64'sd0 : nsum[63:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`RTP_ASSERT_SAME(a_pop_idle, clk, arst_n, pop, (st_q == BS_IDLE) && !q_empty)
	`RTP_ASSERT_SAME(a_load_free, clk, arst_n, load, !out_valid_q || out_ready)
	`RTP_ASSERT_NEXT(a_load_shown, clk, arst_n, load, out_valid && (st_q == BS_IDLE))
	`RTP_ASSERT_SAME(a_err_zero, clk, arst_n, out_valid && out_data.status,
		out_data.timestamp_ns == 64'sd0)

endmodule

/* src/rfc3339_timestamp_parse.sv */
// Timestamp text parser: takes one character per transaction, one per cycle when not
// stalled, and on the transaction marked last_char returns status and signed UTC
// nanoseconds since 1970. The front parses characters at one a cycle and hands each
// finished timestamp to a two-entry queue; the back takes one timestamp at a time from
// the queue and turns it into nanoseconds in a sequence of steps (range checks, day
// count, seconds, two partial products of the nanosecond multiply, result). The input
// stalls only when both queue entries wait.
module rfc3339_timestamp_parse #(
	parameter int FRACTION_DIGITS = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rtp_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rtp_pkg::out_t out_data
);
	import rtp_pkg::*;

	logic push, pop, q_full, q_empty;
	rec_t push_rec, pop_rec;

	rtp_front #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (push),
		.push_rec (push_rec),
		.q_full   (q_full)
	);

	rtp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.pop_rec  (pop_rec)
	);

	rtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop       (pop),
		.pop_rec   (pop_rec),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
